### rtl/bflc_pkg.sv
// shared constants, codes and controller/datapath interface types for the free list cache
`timescale 1ns / 1ps
`default_nettype none
package bflc_pkg;

  localparam int GLOBAL_DEPTH = 1024;
  localparam int NUM_CLIENTS  = 4;
  localparam int MAX_BATCH    = 16;
  localparam int HANDLE_WIDTH = 16;

  localparam int LOCAL_DEPTH = 2 * MAX_BATCH;
  localparam int LRAM_DEPTH  = NUM_CLIENTS * LOCAL_DEPTH;

  localparam int GCNT_W   = $clog2(GLOBAL_DEPTH + 1);
  localparam int GADDR_W  = $clog2(GLOBAL_DEPTH);
  localparam int LCNT_W   = $clog2(LOCAL_DEPTH + 1);
  localparam int LIDX_W   = $clog2(LOCAL_DEPTH);
  localparam int CLIENT_W = 2;
  localparam int LADDR_W  = CLIENT_W + LIDX_W;
  localparam int BATCH_W  = 5;
  localparam int MOVED_W  = 5;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam int IN_FIELDS_W  = CLIENT_W + HANDLE_WIDTH;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = HANDLE_WIDTH + MOVED_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(8);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SEED  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_REFILL,
    S_REFILL_WR,
    S_POP,
    S_POP_DATA,
    S_SPILL,
    S_SPILL_WR,
    S_PUSH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic seed_push;
    logic refill_rd;
    logic refill_wr;
    logic spill_rd;
    logic spill_wr;
    logic pop_rd;
    logic pop_data;
    logic push_local;
    logic set_empty;
    logic set_full;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic lcnt_zero;
    logic spill_need;
    logic refill_go;
    logic spill_go;
    logic gfull;
    logic lfull;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

### rtl/bflc_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bflc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/bflc_ctrl.sv
// request sequencer: steps seed, refill, spill, pop and push of one request
`timescale 1ns / 1ps
`default_nettype none
module bflc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire bflc_pkg::sts_t sts,
  output bflc_pkg::cmd_t     cmd
);
  import bflc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_SEED: begin
            if (sts.gfull) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.seed_push = 1'b1;
            end
            state_nxt = S_FINISH;
          end
          OP_ALLOC: state_nxt = sts.lcnt_zero ? S_REFILL : S_POP;
          OP_FREE:  state_nxt = sts.spill_need ? S_SPILL : S_PUSH;
          default:  state_nxt = S_FINISH;
        endcase
      end
      S_REFILL: begin
        if (sts.refill_go) begin
          cmd.refill_rd = 1'b1;
          state_nxt     = S_REFILL_WR;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_REFILL_WR: begin
        cmd.refill_wr = 1'b1;
        state_nxt     = S_REFILL;
      end
      S_POP: begin
        if (sts.lcnt_zero) begin
          cmd.set_empty = 1'b1;
          state_nxt     = S_FINISH;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP_DATA;
        end
      end
      S_POP_DATA: begin
        cmd.pop_data = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_SPILL: begin
        if (sts.spill_go) begin
          if (sts.gfull) begin
            cmd.set_full = 1'b1;
            state_nxt    = S_PUSH;
          end else begin
            cmd.spill_rd = 1'b1;
            state_nxt    = S_SPILL_WR;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_SPILL_WR: begin
        cmd.spill_wr = 1'b1;
        state_nxt    = S_SPILL;
      end
      S_PUSH: begin
        if (sts.lfull) begin
          cmd.set_full = 1'b1;
        end else begin
          cmd.push_local = 1'b1;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/bflc_dp.sv
// datapath: counts, stack memories, request and result registers
`timescale 1ns / 1ps
`default_nettype none
module bflc_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [bflc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [bflc_pkg::OP_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [bflc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic      [bflc_pkg::STATUS_W-1:0]   out_tuser,
  input  wire logic                            cfg_valid,
  input  wire logic [bflc_pkg::BATCH_W-1:0]    cfg_data,
  input  wire bflc_pkg::cmd_t                  cmd,
  output bflc_pkg::sts_t                       sts
);
  import bflc_pkg::*;

  op_t                     op_r;
  logic [CLIENT_W-1:0]     client_r;
  logic [HANDLE_WIDTH-1:0] handle_r;
  logic [MOVED_W-1:0]      moved_r;
  status_t                 status_r;
  logic [HANDLE_WIDTH-1:0] granted_r;
  logic [BATCH_W-1:0]      batch_r;
  logic [GCNT_W-1:0]       gcount_r;
  logic [GCNT_W-1:0]       gcount_nxt;
  logic [LCNT_W-1:0]       lcnt_r [NUM_CLIENTS];
  logic [LCNT_W-1:0]       lcnt_nxt;

  logic                    out_valid_r;
  logic [HANDLE_WIDTH-1:0] out_granted_r;
  logic [MOVED_W-1:0]      out_moved_r;
  status_t                 out_status_r;

  logic [LCNT_W-1:0]       lcnt_cur;
  logic [LCNT_W-1:0]       lcnt_dec;
  logic [GCNT_W-1:0]       gcount_dec;
  logic [BATCH_W-1:0]      b_eff;
  logic [BATCH_W:0]        two_b;

  logic                    g_we;
  logic [GADDR_W-1:0]      g_waddr;
  logic [HANDLE_WIDTH-1:0] g_wdata;
  logic [GADDR_W-1:0]      g_raddr;
  logic [HANDLE_WIDTH-1:0] g_rdata;
  logic                    l_we;
  logic [LADDR_W-1:0]      l_waddr;
  logic [HANDLE_WIDTH-1:0] l_wdata;
  logic [LADDR_W-1:0]      l_raddr;
  logic [HANDLE_WIDTH-1:0] l_rdata;

  assign lcnt_cur   = lcnt_r[client_r];
  assign lcnt_dec   = lcnt_cur - 1'b1;
  assign gcount_dec = gcount_r - 1'b1;
  assign b_eff      = (batch_r > BATCH_W'(MAX_BATCH)) ? BATCH_W'(MAX_BATCH) : batch_r;
  assign two_b      = {b_eff, 1'b0};

  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.lcnt_zero  = (lcnt_cur == '0);
    sts.spill_need = ({1'b0, lcnt_cur} >= {{(LCNT_W - BATCH_W){1'b0}}, two_b});
    sts.refill_go  = (moved_r < b_eff) && (gcount_r != '0)
                     && (lcnt_cur < LCNT_W'(LOCAL_DEPTH));
    sts.spill_go   = (moved_r < b_eff) && (lcnt_cur != '0);
    sts.gfull      = (gcount_r >= GCNT_W'(GLOBAL_DEPTH));
    sts.lfull      = (lcnt_cur >= LCNT_W'(LOCAL_DEPTH));
    sts.out_busy   = out_valid_r && !out_tready;
  end

  always_comb begin
    gcount_nxt = gcount_r;
    lcnt_nxt   = lcnt_cur;
    if (cmd.seed_push || cmd.spill_wr) begin
      gcount_nxt = gcount_r + 1'b1;
    end else if (cmd.refill_rd) begin
      gcount_nxt = gcount_dec;
    end
    if (cmd.refill_wr || cmd.push_local) begin
      lcnt_nxt = lcnt_cur + 1'b1;
    end else if (cmd.spill_rd || cmd.pop_rd) begin
      lcnt_nxt = lcnt_dec;
    end
  end

  // stack memories
  assign g_we    = cmd.seed_push || cmd.spill_wr;
  assign g_waddr = gcount_r[GADDR_W-1:0];
  assign g_wdata = cmd.spill_wr ? l_rdata : handle_r;
  assign g_raddr = gcount_dec[GADDR_W-1:0];

  assign l_we    = cmd.refill_wr || cmd.push_local;
  assign l_waddr = {client_r, lcnt_cur[LIDX_W-1:0]};
  assign l_wdata = cmd.refill_wr ? g_rdata : handle_r;
  assign l_raddr = {client_r, lcnt_dec[LIDX_W-1:0]};

  bflc_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (GLOBAL_DEPTH)
  ) u_global_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  bflc_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (LRAM_DEPTH)
  ) u_local_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcount_r    <= '0;
      batch_r     <= BATCH_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        lcnt_r[i] <= '0;
      end
    end else begin
      gcount_r         <= gcount_nxt;
      lcnt_r[client_r] <= lcnt_nxt;
      if (cfg_valid) begin
        batch_r <= cfg_data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= op_t'(in_tuser);
      client_r  <= in_tdata[CLIENT_W-1:0];
      handle_r  <= in_tdata[CLIENT_W +: HANDLE_WIDTH];
      moved_r   <= '0;
      status_r  <= ST_OK;
      granted_r <= '0;
    end else begin
      if (cmd.refill_wr || cmd.spill_wr) begin
        moved_r <= moved_r + 1'b1;
      end
      if (cmd.set_full) begin
        status_r <= ST_FULL;
      end else if (cmd.set_empty) begin
        status_r <= ST_EMPTY;
      end
      if (cmd.pop_data) begin
        granted_r <= l_rdata;
      end
    end
    if (cmd.load_out) begin
      out_granted_r <= granted_r;
      out_moved_r   <= moved_r;
      out_status_r  <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_moved_r, out_granted_r});
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

### rtl/batched_free_list_cache.sv
// each handle moved by a refill or spill is read from one stack, then written to the other;
// one memory access per stack per cycle
// throughput: one request in flight; the next is taken once the result is registered
// reset: synchronous active-low rst_n clears the global and local counts, batch_size returns to 8,
// stack memories are not cleared and no clearing pass runs
`timescale 1ns / 1ps
`default_nettype none
module batched_free_list_cache (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [bflc_pkg::IN_DATA_W-1:0]  in_tdata,   // client, handle, zero pad
  input  wire logic [bflc_pkg::OP_W-1:0]       in_tuser,   // operation
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [bflc_pkg::OUT_DATA_W-1:0] out_tdata,  // granted_handle, moved_count, zero pad
  output logic      [bflc_pkg::STATUS_W-1:0]   out_tuser,  // status
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bflc_pkg::BATCH_W-1:0]    cfg_data    // batch_size
);
  import bflc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bflc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bflc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

### rtl/bflc_checker.sv
// port-level checks for the free list cache and their bind
`timescale 1ns / 1ps
`default_nettype none
module bflc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [bflc_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [bflc_pkg::STATUS_W-1:0]   out_tuser
);
  import bflc_pkg::*;

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a request is in progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_EMPTY || out_tuser == ST_FULL))
    else $error("bad status code");

  a_moved_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[HANDLE_WIDTH +: MOVED_W] <= MOVED_W'(MAX_BATCH)))
    else $error("moved count above batch limit");

  // handle only granted on ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[HANDLE_WIDTH-1:0] == '0))
    else $error("handle granted with failing status");

endmodule

bind batched_free_list_cache bflc_checker u_bflc_checker (.*);
`default_nettype wire
